/* rtl/core/bfc_pkg.sv */
package bfc_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int KEY_BYTES     = 16;
	localparam int LEN_W         = 5;
	localparam int FREQ_W        = 32;
	localparam int ENTRY_W       = 64 + 64 + FREQ_W;

	localparam logic [1:0] OP_BYTE   = 2'd0;
	localparam logic [1:0] OP_EOI    = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_STOP  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [7:0] NEWLINE = 8'd10;
	localparam logic [1:0] KEY_LINE = 2'd1;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        entry_valid;
		logic [63:0] key_upper;
		logic [63:0] key_lower;
		logic [31:0] frequency;
		logic        final_entry;
	} result_t;

	typedef struct packed {
		logic [63:0]       key_upper;
		logic [63:0]       key_lower;
		logic [FREQ_W-1:0] frequency;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SH_RD,
		S_SH_WR,
		S_INS_WR,
		S_INC_WR,
		S_RO_RD,
		S_RO_OUT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic srch_read;
		logic srch_step;
		logic shift_init;
		logic shift_read;
		logic shift_write;
		logic ins_write;
		logic inc_write;
		logic ro_read;
		logic ro_load;
		logic done_load;
		logic mark_full;
	} cmd_t;

	typedef struct packed {
		logic item_valid;
		logic out_free;
		logic need_insert;
		logic need_read;
		logic srch_end;
		logic cmp_less;
		logic cmp_eq;
		logic full;
		logic pos_at_end;
		logic shift_last;
	} sts_t;

endpackage

/* rtl/core/bfc_ram.sv */
module bfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/bfc_ctrl.sv */
module bfc_ctrl
	import bfc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   item_stall
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sts.item_valid && sts.out_free) begin
					if (sts.need_insert) state_d = S_SRCH_RD;
					else if (sts.need_read) state_d = S_RO_RD;
				end
			end
			S_SRCH_RD: begin
				if (!sts.srch_end) state_d = S_SRCH_CMP;
				else if (sts.full) state_d = S_DONE;
				else if (sts.pos_at_end) state_d = S_INS_WR;
				else state_d = S_SH_RD;
			end
			S_SRCH_CMP: begin
				if (sts.cmp_less) state_d = S_SRCH_RD;
				else if (sts.cmp_eq) state_d = S_INC_WR;
				else if (sts.full) state_d = S_DONE;
				else if (sts.pos_at_end) state_d = S_INS_WR;
				else state_d = S_SH_RD;
			end
			S_SH_RD:  state_d = S_SH_WR;
			S_SH_WR:  state_d = sts.shift_last ? S_INS_WR : S_SH_RD;
			S_INS_WR: state_d = S_DONE;
			S_INC_WR: state_d = S_DONE;
			S_RO_RD:  state_d = S_RO_OUT;
			S_RO_OUT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				item_stall = !sts.out_free;
				cmd.accept = sts.item_valid && sts.out_free;
			end
			S_SRCH_RD: begin
				// search hit the end: key is new
				cmd.srch_read  = !sts.srch_end;
				cmd.mark_full  = sts.srch_end && sts.full;
				cmd.shift_init = sts.srch_end && !sts.full;
			end
			S_SRCH_CMP: begin
				cmd.srch_step  = sts.cmp_less;
				cmd.mark_full  = !sts.cmp_less && !sts.cmp_eq && sts.full;
				cmd.shift_init = !sts.cmp_less && !sts.cmp_eq && !sts.full;
			end
			S_SH_RD:  cmd.shift_read  = 1'b1;
			S_SH_WR:  cmd.shift_write = 1'b1;
			S_INS_WR: cmd.ins_write   = 1'b1;
			S_INC_WR: cmd.inc_write   = 1'b1;
			S_RO_RD:  cmd.ro_read     = 1'b1;
			S_RO_OUT: cmd.ro_load     = sts.out_free;
			S_DONE:   cmd.done_load   = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* rtl/core/bfc_dpath.sv */
module bfc_dpath
	import bfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             item_valid,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  cmd_t             cmd,
	output sts_t             sts
);

	logic [LEN_W-1:0] len_q;
	logic [1:0]       line_idx_q;
	logic [4:0]       byte_cnt_q;
	logic [63:0]      pend_up_q, pend_lo_q;
	logic [63:0]      key_up_q, key_lo_q;
	logic             stop_q;
	logic [CNT_W-1:0] cnt_q, rptr_q, srch_q, idx_q;
	logic [1:0]       res_st_q;
	logic             out_valid_q;
	result_t          out_q;

	logic [LEN_W-1:0] eff_len;
	logic             closing, short_line, need_read, take_key_byte;
	logic [CNT_W-1:0] idx_m1;
	logic             ram_we, ram_re;
	logic [ADDR_W-1:0] waddr, raddr;
	entry_t           wdata, rdata;
	logic [1:0]       simple_st;
	logic             out_valid_d;
	result_t          out_d;

	always_comb begin
		if (len_q == '0) eff_len = LEN_W'(1);
		else if (len_q > LEN_W'(KEY_BYTES)) eff_len = LEN_W'(KEY_BYTES);
		else eff_len = len_q;
	end

	assign closing = !stop_q && ((item.op == OP_BYTE && item.data_byte == NEWLINE) ||
		(item.op == OP_EOI && byte_cnt_q != '0));
	assign short_line = byte_cnt_q < eff_len;
	assign need_read = item.op == OP_READ && rptr_q < cnt_q;
	assign take_key_byte = line_idx_q == KEY_LINE && byte_cnt_q < eff_len;
	assign idx_m1 = idx_q - CNT_W'(1);

	always_comb begin
		simple_st = ST_OK;
		if ((item.op == OP_BYTE || item.op == OP_EOI) && stop_q) simple_st = ST_STOP;
		else if (closing && line_idx_q == KEY_LINE && short_line) simple_st = ST_STOP;
		else if (item.op == OP_READ && !need_read) simple_st = ST_EMPTY;
	end

	assign sts.item_valid  = item_valid;
	assign sts.out_free    = !out_valid_q || !result_stall;
	assign sts.need_insert = closing && line_idx_q == KEY_LINE && !short_line;
	assign sts.need_read   = need_read;
	assign sts.srch_end    = srch_q == cnt_q;
	assign sts.cmp_less    = rdata.key_upper < key_up_q ||
		(rdata.key_upper == key_up_q && rdata.key_lower < key_lo_q);
	assign sts.cmp_eq      = rdata.key_upper == key_up_q && rdata.key_lower == key_lo_q;
	assign sts.full        = cnt_q == CNT_W'(TABLE_ENTRIES);
	assign sts.pos_at_end  = cnt_q == srch_q;
	assign sts.shift_last  = idx_m1 == srch_q;

	// table port muxing
	always_comb begin
		ram_re = cmd.srch_read || cmd.shift_read || cmd.ro_read;
		raddr  = srch_q[ADDR_W-1:0];
		if (cmd.shift_read) raddr = idx_m1[ADDR_W-1:0];
		else if (cmd.ro_read) raddr = rptr_q[ADDR_W-1:0];
		ram_we = cmd.shift_write || cmd.ins_write || cmd.inc_write;
		waddr  = cmd.shift_write ? idx_q[ADDR_W-1:0] : srch_q[ADDR_W-1:0];
		wdata  = rdata;
		if (cmd.ins_write) begin
			wdata = '{key_upper: key_up_q, key_lower: key_lo_q, frequency: FREQ_W'(1)};
		end else if (cmd.inc_write && rdata.frequency != '1) begin
			wdata.frequency = rdata.frequency + FREQ_W'(1);
		end
	end

	bfc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// result register: a waiting beat leaves on !result_stall, a new one loads
	always_comb begin
		out_valid_d = out_valid_q && result_stall;
		if ((cmd.accept && !sts.need_insert && !need_read) || cmd.ro_load || cmd.done_load)
			out_valid_d = 1'b1;
		out_d = out_q;
		if (cmd.accept) begin
			out_d        = '0;
			out_d.status = simple_st;
		end
		if (cmd.done_load) begin
			out_d        = '0;
			out_d.status = res_st_q;
		end
		if (cmd.ro_load) begin
			out_d             = '0;
			out_d.status      = ST_OK;
			out_d.entry_valid = 1'b1;
			out_d.key_upper   = rdata.key_upper;
			out_d.key_lower   = rdata.key_lower;
			out_d.frequency   = rdata.frequency;
			out_d.final_entry = (rptr_q + CNT_W'(1)) == cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= LEN_W'(KEY_BYTES);
			line_idx_q <= '0;
			byte_cnt_q <= '0;
			pend_up_q  <= '0;
			pend_lo_q  <= '0;
			stop_q     <= 1'b0;
			cnt_q      <= '0;
			rptr_q     <= '0;
			srch_q     <= '0;
			idx_q      <= '0;
			res_st_q   <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) len_q <= cfg_data;
			out_valid_q <= out_valid_d;
			if (cmd.accept) begin
				res_st_q <= ST_OK;
				srch_q   <= '0;
				if (closing) begin
					if (line_idx_q == KEY_LINE && short_line) stop_q <= 1'b1;
					line_idx_q <= line_idx_q + 2'd1;
					byte_cnt_q <= '0;
					pend_up_q  <= '0;
					pend_lo_q  <= '0;
				end else if (!stop_q && item.op == OP_BYTE) begin
					if (take_key_byte) begin
						if (!byte_cnt_q[3]) pend_up_q[{~byte_cnt_q[2:0], 3'b000} +: 8] <= item.data_byte;
						else pend_lo_q[{~byte_cnt_q[2:0], 3'b000} +: 8] <= item.data_byte;
					end
					if (byte_cnt_q != 5'd31) byte_cnt_q <= byte_cnt_q + 5'd1;
				end
			end
			if (cmd.srch_step) srch_q <= srch_q + CNT_W'(1);
			if (cmd.shift_init) idx_q <= cnt_q;
			if (cmd.shift_write) idx_q <= idx_m1;
			if (cmd.ins_write) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.mark_full) res_st_q <= ST_FULL;
			if (cmd.ro_load) rptr_q <= rptr_q + CNT_W'(1);
		end
	end

	// search key registers and payload of the result register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_up_q <= pend_up_q;
			key_lo_q <= pend_lo_q;
		end
		out_q <= out_d;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_ENTRIES)) else $error("entry count beyond table size");
	a_rptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rptr_q <= cnt_q) else $error("readout pointer past entry count");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(stop_q)) else $error("stop flag cleared without reset");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.shift_write, cmd.ins_write, cmd.inc_write}) <= 1)
		else $error("conflicting table writes");

endmodule

/* rtl/core/barcode_frequency_counter_unit.sv */
// Barcode frequency counter: builds a sorted key/count table from a read file.
// item channel (item_valid/item_stall/item): one beat per file byte (op byte),
//   end of input (op eoi) or readout request (op read).
// result channel (result_valid/result_stall/result): exactly one beat per item.
// cfg_we/cfg_data write the key length (reset 16); write only while idle.
// Most items give their result in the cycle after acceptance; a readout
//   passes a read state and an output state. An item closing a key line
//   runs a linear search of the table, a read and a compare per smaller
//   entry; a match bumps its count, else every larger entry moves up one slot
//   (read, write) unless full, then the entry is written; the sequencer walks
//   the table memory. One item is in work at a time; bytes flow back to back.
// Reset empties the table at once (entry count to zero, no clearing pass),
//   sets length to 16 and clears the stop flag.
// A stalled result holds in the output register; a new item is accepted in
//   the same cycle as the waiting result leaves.
module barcode_frequency_counter_unit
	import bfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	cmd_t cmd;
	sts_t sts;

	bfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.cmd       (cmd),
		.item_stall(item_stall)
	);

	bfc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

/* tb/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bfc_pkg::*;

	class key_count_tracker;
		int unsigned key_len;
		int unsigned line_idx;
		int unsigned byte_cnt;
		logic [63:0] pend_up, pend_lo;
		bit stopped;
		int unsigned n_entries, rd_ptr;
		logic [63:0] tab_up[TABLE_ENTRIES];
		logic [63:0] tab_lo[TABLE_ENTRIES];
		logic [31:0] tab_freq[TABLE_ENTRIES];
		result_t owed_results[$];
		int unsigned n_bad, n_checked, n_items, n_inserts, n_entries_read, n_full;

		function new();
			key_len = KEY_BYTES;
			line_idx = 0; byte_cnt = 0; pend_up = '0; pend_lo = '0;
			stopped = 0; n_entries = 0; rd_ptr = 0;
			n_bad = 0; n_checked = 0; n_items = 0; n_inserts = 0;
			n_entries_read = 0; n_full = 0;
		endfunction

		function int unsigned eff_len();
			if (key_len == 0) return 1;
			if (key_len > KEY_BYTES) return KEY_BYTES;
			return key_len;
		endfunction

		function logic [1:0] count_key(logic [63:0] up, logic [63:0] lo);
			int unsigned pos;
			pos = 0;
			while (pos < n_entries && {tab_up[pos], tab_lo[pos]} < {up, lo}) pos++;
			if (pos < n_entries && tab_up[pos] == up && tab_lo[pos] == lo) begin
				if (tab_freq[pos] != 32'hFFFF_FFFF) tab_freq[pos]++;
				return ST_OK;
			end
			if (n_entries >= TABLE_ENTRIES) begin
				n_full++;
				return ST_FULL;
			end
			for (int i = n_entries; i > pos; i--) begin
				tab_up[i] = tab_up[i-1];
				tab_lo[i] = tab_lo[i-1];
				tab_freq[i] = tab_freq[i-1];
			end
			tab_up[pos] = up; tab_lo[pos] = lo; tab_freq[pos] = 1;
			n_entries++;
			n_inserts++;
			return ST_OK;
		endfunction

		function logic [1:0] end_line();
			logic [1:0] st;
			st = ST_OK;
			if (line_idx == KEY_LINE) begin
				if (byte_cnt >= eff_len()) st = count_key(pend_up, pend_lo);
				else begin
					stopped = 1;
					st = ST_STOP;
				end
			end
			line_idx = (line_idx + 1) % 4;
			byte_cnt = 0; pend_up = '0; pend_lo = '0;
			return st;
		endfunction

		function void note_item(item_t it);
			result_t r;
			r = '0;
			n_items++;
			if (it.op == OP_BYTE || it.op == OP_EOI) begin
				if (stopped) r.status = ST_STOP;
				else if (it.op == OP_BYTE) begin
					if (it.data_byte == NEWLINE) r.status = end_line();
					else begin
						if (line_idx == KEY_LINE && byte_cnt < eff_len()) begin
							if (byte_cnt < 8)
								pend_up[(7 - byte_cnt) * 8 +: 8] = it.data_byte;
							else
								pend_lo[(7 - (byte_cnt - 8)) * 8 +: 8] = it.data_byte;
						end
						if (byte_cnt < 31) byte_cnt++;
					end
				end else if (byte_cnt > 0) r.status = end_line();
			end else if (it.op == OP_READ) begin
				if (rd_ptr < n_entries) begin
					r.entry_valid = 1;
					r.key_upper = tab_up[rd_ptr];
					r.key_lower = tab_lo[rd_ptr];
					r.frequency = tab_freq[rd_ptr];
					r.final_entry = (rd_ptr + 1 == n_entries);
					rd_ptr++;
					n_entries_read++;
				end else r.status = ST_EMPTY;
			end
			owed_results.push_back(r);
		endfunction

		task report(string what, logic [127:0] got, logic [127:0] want);
			n_bad++;
			$display("%0t: bad %s: got %0h want %0h", $time, what, got, want);
		endtask

		task check_result(result_t got);
			result_t want;
			n_checked++;
			if (owed_results.size() == 0) begin
				report("beat with nothing owed", got.status, 0);
				return;
			end
			want = owed_results.pop_front();
			if (got.status != want.status) report("status", got.status, want.status);
			if (got.entry_valid != want.entry_valid)
				report("entry_valid", got.entry_valid, want.entry_valid);
			if (got.key_upper != want.key_upper)
				report("key_upper", got.key_upper, want.key_upper);
			if (got.key_lower != want.key_lower)
				report("key_lower", got.key_lower, want.key_lower);
			if (got.frequency != want.frequency)
				report("frequency", got.frequency, want.frequency);
			if (got.final_entry != want.final_entry)
				report("final_entry", got.final_entry, want.final_entry);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [LEN_W-1:0] cfg_data = '0;
	logic item_valid = 0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 0;
	result_t result;

	key_count_tracker sb = new();
	bit quiet = 0;
	int hold_req = 0;
	int line_target = 0;

	always #2 clk = ~clk;

	barcode_frequency_counter_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	initial forever begin
		@(negedge clk);
		if (hold_req > 0) begin
			result_stall = 1;
			hold_req--;
		end else result_stall = quiet ? 1'b0 : ($urandom_range(99) < 14);
	end

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall) sb.check_result(result);

	initial begin
		#20_000_000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

	// called at a falling edge, returns at a falling edge
	task automatic push(input logic [1:0] op, input logic [7:0] b);
		item_t it;
		it.op = op;
		it.data_byte = b;
		if (!quiet)
			while ($urandom_range(99) < 14) begin
				item_valid = 0;
				@(negedge clk);
			end
		item_valid = 1;
		item = it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid = 0;
		while (sb.owed_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_len(input logic [LEN_W-1:0] v);
		drain();
		cfg_we = 1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
		sb.key_len = v;
	endtask

	function automatic logic [7:0] any_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == NEWLINE);
		return b;
	endfunction

	function automatic logic [7:0] base_byte();
		case ($urandom_range(3))
			0: return "A";
			1: return "C";
			2: return "G";
			default: return "T";
		endcase
	endfunction

	// next beat of a well-formed stream, with some noise mixed in
	task automatic stream_beat();
		int unsigned r;
		r = $urandom_range(99);
		if (sb.byte_cnt == 0)
			line_target = (sb.line_idx == KEY_LINE) ? sb.eff_len() + $urandom_range(3)
				: $urandom_range(5);
		if (r < 5) push(OP_READ, 8'($urandom_range(255)));
		else if (r < 7) push(OP_UNUSED, 8'($urandom_range(255)));
		else if (r < 10 && !(sb.line_idx == KEY_LINE && sb.byte_cnt < sb.eff_len()))
			push(OP_EOI, 8'($urandom_range(255)));
		else if (sb.byte_cnt < line_target)
			push(OP_BYTE, (sb.line_idx == KEY_LINE && $urandom_range(9) != 0)
				? base_byte() : any_byte());
		else push(OP_BYTE, NEWLINE);
	endtask

	task automatic align_record();
		while (sb.line_idx != 0 || sb.byte_cnt != 0) begin
			if (sb.line_idx == KEY_LINE && sb.byte_cnt < sb.eff_len()) push(OP_BYTE, "A");
			else push(OP_BYTE, NEWLINE);
		end
	endtask

	initial begin
		logic [LEN_W-1:0] lens[4];
		lens = '{5'd0, 5'd3, 5'd31, 5'd1};
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// empty table, unused op, end of input on an empty line, a key closed by end of input, readout
		push(OP_READ, 8'h00);
		push(OP_UNUSED, 8'hFF);
		push(OP_EOI, 8'h00);
		push(OP_BYTE, NEWLINE);
		for (int i = 0; i < 16; i++) push(OP_BYTE, i < 8 ? 8'hFF : 8'h00);
		push(OP_EOI, 8'h00);   // closes the key line without a newline
		push(OP_BYTE, NEWLINE);
		push(OP_BYTE, NEWLINE);
		push(OP_READ, 8'h00);
		push(OP_READ, 8'h00);

		for (int p = 0; p < 5; p++) begin
			set_len(p < 4 ? lens[p] : 5'($urandom_range(1, 16)));
			quiet = (p == 2);
			for (int n = 0; n < 190; n++) begin
				if (p == 1 && n == 40) hold_req = 300;
				stream_beat();
			end
			align_record();
		end

		set_len(5'd2);
		repeat (40) push(OP_READ, 8'h00);

		// a short key line stops counting for good; readout still works
		push(OP_BYTE, NEWLINE);
		push(OP_BYTE, "G");
		push(OP_BYTE, NEWLINE);
		push(OP_BYTE, "T");
		push(OP_EOI, 8'h00);
		repeat (4) push(OP_READ, 8'h00);
		drain();
		repeat (20) @(negedge clk);

		$display("%0d beats in, %0d results checked, %0d inserts, %0d entries read out",
			sb.n_items, sb.n_checked, sb.n_inserts, sb.n_entries_read);
		$display("lengths 0..31 written, %0d key(s) dropped on a full table, stop path hit: %0d",
			sb.n_full, sb.stopped);
		if (sb.n_bad == 0 && sb.owed_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
